// ===== sv/ioct_pkg.sv =====
`default_nettype none
package ioct_pkg;

  localparam logic [1:0] MODE_POST     = 2'd0;
  localparam logic [1:0] MODE_DISPATCH = 2'd1;
  localparam logic [1:0] MODE_COMPLETE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] job_tag;
    logic [31:0] done_seq;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] assigned_seq;
    logic [31:0] out_tag;
    logic [31:0] out_seq;
    logic [31:0] retired_upto;
  } rsp_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== sv/in_order_completion_tracker.sv =====
`default_nettype none
// post, dispatch, error and ignored requests: accepted in S_IDLE, then the result register
// completion: accepted in S_IDLE, through S_WALK when the oldest sequence is done, then the
// result register; the retire walk reads one done bit per cycle from the done-bit memory
// a new request is taken while the previous result still waits on rsp_ready
// after rst the done-bit memory is cleared, one entry a cycle, with req_ready low
module in_order_completion_tracker #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ioct_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ioct_pkg::rsp_t rsp
);
  import ioct_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);
  localparam logic [31:0]   DEPTH32  = 32'(DEPTH);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  state_t        state, state_next;
  logic [CW-1:0] occ, occ_next;
  logic [AW-1:0] wr_idx, wr_idx_next;
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic [AW-1:0] ret_idx, ret_idx_next;
  logic [AW-1:0] clr_idx, clr_idx_next;
  logic [31:0]   next_number, next_number_next;
  logic [31:0]   retired_count, retired_count_next;

  logic [1:0]    p_status, p_status_next;
  logic [31:0]   p_assigned, p_assigned_next;
  logic [31:0]   p_seq, p_seq_next;
  logic          p_from_ram, p_from_ram_next;
  logic          rsp_load;

  logic          tag_we, tag_re;
  logic [31:0]   tag_rdata;
  logic          bit_we, bit_re;
  logic [AW-1:0] bit_waddr, bit_raddr;
  logic [0:0]    bit_wdata, bit_rdata;

  logic [31:0]   unretired, dispatched, off;
  logic [AW:0]   slot_sum;
  logic [AW-1:0] slot, ret_idx_inc;

  ioct_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr(wr_idx),
    .wdata(req.job_tag),
    .re   (tag_re),
    .raddr(rd_idx),
    .rdata(tag_rdata)
  );

  ioct_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_done_ram (
    .clk  (clk),
    .we   (bit_we),
    .waddr(bit_waddr),
    .wdata(bit_wdata),
    .re   (bit_re),
    .raddr(bit_raddr),
    .rdata(bit_rdata)
  );

  assign unretired   = next_number - retired_count;
  assign dispatched  = next_number - 32'(occ) - retired_count;
  assign off         = req.done_seq - retired_count - 32'd1;
  assign ret_idx_inc = idx_inc(ret_idx);
  // ring slot of the completed sequence, relative to the oldest unretired one
  assign slot_sum    = {1'b0, ret_idx} + {1'b0, off[AW-1:0]};
  assign slot        = (slot_sum >= DEPTH_W) ? AW'(slot_sum - DEPTH_W) : slot_sum[AW-1:0];

  always_comb begin
    state_next         = state;
    occ_next           = occ;
    wr_idx_next        = wr_idx;
    rd_idx_next        = rd_idx;
    ret_idx_next       = ret_idx;
    clr_idx_next       = clr_idx;
    next_number_next   = next_number;
    retired_count_next = retired_count;
    p_status_next      = p_status;
    p_assigned_next    = p_assigned;
    p_seq_next         = p_seq;
    p_from_ram_next    = p_from_ram;
    tag_we             = 1'b0;
    tag_re             = 1'b0;
    bit_we             = 1'b0;
    bit_waddr          = ret_idx;
    bit_wdata          = 1'b0;
    bit_re             = 1'b0;
    bit_raddr          = ret_idx_inc;
    req_ready          = 1'b0;
    rsp_load           = 1'b0;

    unique case (state)
      S_CLEAR: begin
        bit_we       = 1'b1;
        bit_waddr    = clr_idx;
        clr_idx_next = idx_inc(clr_idx);
        if (clr_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          p_status_next   = STATUS_OK;
          p_assigned_next = '0;
          p_seq_next      = '0;
          p_from_ram_next = 1'b0;
          state_next      = S_EMIT;
          case (req.mode)
            MODE_POST: begin
              if (occ == FULL_CNT || unretired >= DEPTH32) begin
                p_status_next = STATUS_FULL;
              end else begin
                tag_we           = 1'b1;
                wr_idx_next      = idx_inc(wr_idx);
                occ_next         = occ + CW'(1);
                next_number_next = next_number + 32'd1;
                p_assigned_next  = next_number + 32'd1;
              end
            end
            MODE_DISPATCH: begin
              if (occ == '0) begin
                p_status_next = STATUS_EMPTY;
              end else begin
                tag_re          = 1'b1;
                rd_idx_next     = idx_inc(rd_idx);
                occ_next        = occ - CW'(1);
                p_seq_next      = next_number - 32'(occ) + 32'd1;
                p_from_ram_next = 1'b1;
              end
            end
            MODE_COMPLETE: begin
              if (off >= dispatched || off >= DEPTH32) begin
                p_status_next = STATUS_RANGE;
              end else if (off == '0) begin
                // oldest one done: retire it and look at the next bit
                retired_count_next = retired_count + 32'd1;
                ret_idx_next       = ret_idx_inc;
                bit_re             = 1'b1;
                state_next         = S_WALK;
              end else begin
                bit_we    = 1'b1;
                bit_waddr = slot;
                bit_wdata = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (bit_rdata[0]) begin
          bit_we             = 1'b1;
          bit_waddr          = ret_idx;
          bit_wdata          = 1'b0;
          retired_count_next = retired_count + 32'd1;
          ret_idx_next       = ret_idx_inc;
          bit_re             = 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      occ           <= '0;
      wr_idx        <= '0;
      rd_idx        <= '0;
      ret_idx       <= '0;
      clr_idx       <= '0;
      next_number   <= '0;
      retired_count <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      occ           <= occ_next;
      wr_idx        <= wr_idx_next;
      rd_idx        <= rd_idx_next;
      ret_idx       <= ret_idx_next;
      clr_idx       <= clr_idx_next;
      next_number   <= next_number_next;
      retired_count <= retired_count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_status   <= p_status_next;
    p_assigned <= p_assigned_next;
    p_seq      <= p_seq_next;
    p_from_ram <= p_from_ram_next;
    if (rsp_load) begin
      rsp.status       <= p_status;
      rsp.assigned_seq <= p_assigned;
      rsp.out_tag      <= p_from_ram ? tag_rdata : 32'd0;
      rsp.out_seq      <= p_seq;
      rsp.retired_upto <= retired_count;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ioct_ram.sv =====
`default_nettype none
module ioct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
  import ioct_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  always #1 clk = ~clk;

  in_order_completion_tracker #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // tracker state as the testbench sees it
  logic [31:0] tag_mem [DEPTH];
  logic [6:0]  wr_ptr = '0;
  logic [6:0]  rd_ptr = '0;
  logic [31:0] last_seq = '0;
  logic [31:0] retired = '0;
  logic [DEPTH-1:0] done_mask = '0;

  rsp_t        pending_rsp [$];
  logic [31:0] dispatched_seqs [$];

  int errors = 0;
  int sent = 0;
  int checked = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int cycles = 0;
  bit src_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  int hold_len = 0;

  function automatic int ring_count();
    logic [6:0] diff;
    diff = wr_ptr - rd_ptr;
    return int'(diff);
  endfunction

  function automatic rsp_t track_step(input req_t r);
    rsp_t o;
    logic [31:0] occ;
    logic [31:0] dispatched;
    logic [31:0] off;
    o = '0;
    o.status = STATUS_OK;
    occ = 32'(ring_count());
    case (r.mode)
      MODE_POST: begin
        if (occ >= DEPTH || (last_seq - retired) >= DEPTH) begin
          o.status = STATUS_FULL;
        end else begin
          last_seq = last_seq + 1;
          tag_mem[wr_ptr[5:0]] = r.job_tag;
          wr_ptr = wr_ptr + 1;
          o.assigned_seq = last_seq;
        end
      end
      MODE_DISPATCH: begin
        if (occ == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.out_tag = tag_mem[rd_ptr[5:0]];
          o.out_seq = last_seq - occ + 1;
          rd_ptr = rd_ptr + 1;
        end
      end
      MODE_COMPLETE: begin
        dispatched = (last_seq - occ) - retired;
        off = r.done_seq - retired - 1;
        if (off >= dispatched || off >= DEPTH) begin
          o.status = STATUS_RANGE;
        end else begin
          done_mask[off[5:0]] = 1'b1;
          // walk the contiguous finished run
          while (done_mask[0]) begin
            done_mask = done_mask >> 1;
            retired = retired + 1;
          end
        end
      end
      default: ;
    endcase
    o.retired_upto = retired;
    return o;
  endfunction

  // mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 2);
    if (r < 19) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t make_req(input logic [1:0] mode, input logic [31:0] tag,
                                    input logic [31:0] seq);
    req_t r;
    r.mode = mode;
    r.job_tag = tag;
    r.done_seq = seq;
    return r;
  endfunction

  // leaves req_valid high after the accepting edge; the next call or
  // source_idle decides what happens next
  task automatic send_req(input req_t r);
    int gap;
    rsp_t want;
    gap = 0;
    if (src_gaps && $urandom_range(0, 1) == 1) gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    want = track_step(r);
    pending_rsp.push_back(want);
    sent++;
    if (r.mode == MODE_DISPATCH && want.status == STATUS_OK)
      dispatched_seqs.push_back(want.out_seq);
  endtask

  task automatic source_idle();
    req_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    source_idle();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // response sink: random stalls plus an explicit long hold-off
  initial begin : rsp_sink
    int len;
    forever begin
      @(posedge clk);
      len = 0;
      if (hold_len > 0) begin
        len = hold_len;
        hold_len = 0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        len = pick_gap();
      end
      if (len > 0) begin
        rsp_ready <= 1'b0;
        repeat (len - 1) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d assigned %h tag %h seq %h retired %h",
                   rsp.status, rsp.assigned_seq, rsp.out_tag, rsp.out_seq, rsp.retired_upto);
      end else begin
        want = pending_rsp.pop_front();
        checked++;
        status_seen[rsp.status]++;
        if (rsp.status !== want.status || rsp.assigned_seq !== want.assigned_seq ||
            rsp.out_tag !== want.out_tag || rsp.out_seq !== want.out_seq ||
            rsp.retired_upto !== want.retired_upto) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch on result %0d:", checked);
            $display("  expected status %0d assigned %h tag %h seq %h retired %h",
                     want.status, want.assigned_seq, want.out_tag, want.out_seq,
                     want.retired_upto);
            $display("  actual   status %0d assigned %h tag %h seq %h retired %h",
                     rsp.status, rsp.assigned_seq, rsp.out_tag, rsp.out_seq,
                     rsp.retired_upto);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_rsp.size());
      $display("in_order_completion_tracker test failed");
      $finish;
    end
  end

  task automatic test_directed();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    send_req(make_req(MODE_DISPATCH, 32'h0, 32'h0));          // empty ring
    send_req(make_req(MODE_COMPLETE, 32'h0, 32'h0));          // below the window
    send_req(make_req(MODE_COMPLETE, 32'h0, 32'h1));          // never posted
    send_req(make_req(MODE_COMPLETE, 32'hffff_ffff, 32'hffff_ffff));
    send_req(make_req(MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff));
    send_req(make_req(MODE_POST, 32'h0, 32'hffff_ffff));
    send_req(make_req(MODE_POST, 32'hffff_ffff, 32'h0));
    send_req(make_req(MODE_POST, 32'ha5a5_5a5a, 32'h0));
    send_req(make_req(MODE_COMPLETE, 32'h0, 32'h1));          // posted, not dispatched
    send_req(make_req(MODE_DISPATCH, 32'hffff_ffff, 32'h0));
    send_req(make_req(MODE_DISPATCH, 32'h0, 32'h0));
    send_req(make_req(MODE_COMPLETE, 32'h0, 32'h2));          // out of order, no retire
    send_req(make_req(MODE_COMPLETE, 32'h0, 32'h2));          // repeated mark
    send_req(make_req(MODE_COMPLETE, 32'h0, 32'h3));          // not dispatched yet
    send_req(make_req(MODE_COMPLETE, 32'h0, 32'h1));          // retires 1 and 2
    send_req(make_req(MODE_COMPLETE, 32'h0, 32'h1));          // already retired
    send_req(make_req(MODE_DISPATCH, 32'h0, 32'h0));
    send_req(make_req(MODE_DISPATCH, 32'h0, 32'h0));          // empty again
    send_req(make_req(MODE_COMPLETE, 32'h0, 32'h3));
    send_req(make_req(MODE_UNUSED, 32'h0, 32'h0));
    dispatched_seqs.delete();
  endtask

  // fill the ring, then the window, then retire everything in one long walk
  task automatic test_ring_full();
    int i;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    while (ring_count() < DEPTH) send_req(make_req(MODE_POST, $urandom, $urandom));
    send_req(make_req(MODE_POST, $urandom, $urandom));        // ring full
    while (ring_count() > 0) send_req(make_req(MODE_DISPATCH, $urandom, $urandom));
    send_req(make_req(MODE_DISPATCH, $urandom, $urandom));    // empty
    send_req(make_req(MODE_POST, $urandom, $urandom));        // window full
    for (i = dispatched_seqs.size() - 1; i >= 0; i--)
      send_req(make_req(MODE_COMPLETE, $urandom, dispatched_seqs[i]));
    dispatched_seqs.delete();
    wait_drained();
  endtask

  // sink holds off while the source keeps offering requests
  task automatic test_backpressure();
    int i;
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    @(posedge clk);
    hold_len = 400;
    for (i = 0; i < 30; i++)
      send_req(make_req(i[0] ? MODE_DISPATCH : MODE_POST, $urandom, $urandom));
    wait_drained();
  endtask

  task automatic send_random(input int post_pct, output bit counted);
    req_t r;
    int pick;
    int k;
    int idx;
    r.job_tag = $urandom;
    r.done_seq = $urandom;
    pick = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 3) begin
      r.mode = MODE_UNUSED;
      counted = 1'b0;
    end else if (pick < post_pct) begin
      r.mode = MODE_POST;
    end else if (pick < post_pct + (100 - post_pct) / 2) begin
      r.mode = MODE_DISPATCH;
    end else begin
      r.mode = MODE_COMPLETE;
      k = $urandom_range(0, 9);
      if (k < 7 && dispatched_seqs.size() > 0) begin
        idx = $urandom_range(0, dispatched_seqs.size() - 1);
        r.done_seq = dispatched_seqs[idx];
        // sometimes keep it so it gets completed twice
        if ($urandom_range(0, 3) != 0) dispatched_seqs.delete(idx);
      end else if (k == 7) begin
        r.done_seq = retired;
      end else if (k == 8) begin
        r.done_seq = last_seq - 32'(ring_count()) + 1;
      end
    end
    send_req(r);
  endtask

  task automatic test_random();
    int phase;
    int n;
    bit counted;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      src_gaps = phase[0];
      sink_stalls = phase[1];
      n = 0;
      while (n < PHASE_ITEMS) begin
        send_random(phase[2] ? 62 : 38, counted);
        if (counted) n++;
      end
      if (phase == 3) wait_drained();
    end
    source_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_ring_full();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (DEPTH + 8) @(posedge clk);
    $display("%0d requests sent, %0d results checked, last retired sequence %0d",
             sent, checked, retired);
    $display("status counts: ok %0d, full %0d, empty %0d, out of range %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("in_order_completion_tracker test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_rsp.size());
      $display("in_order_completion_tracker test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
